// ===== rtl/core/cst_pkg.sv =====
`default_nettype none

package cst_pkg;

  // Event codes carried on the result stream
  typedef enum logic [1:0] {
    KIND_TOKEN = 2'd0,
    KIND_DELIM = 2'd1,
    KIND_ERROR = 2'd2,
    KIND_END   = 2'd3
  } cst_kind_t;

  // Scanner modes
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_LETTER = 2'd1,
    MODE_PLAIN  = 2'd2,
    MODE_QUOTED = 2'd3
  } cst_mode_t;

  localparam int unsigned POS_W   = 12;
  localparam int unsigned MAX_RES = 3;

  typedef struct packed {
    cst_kind_t          kind;
    logic [7:0]         symbol;
    logic [POS_W-1:0]   offset;
    logic [POS_W-1:0]   length;
    logic               bad_quote;
    logic               last;
  } cst_result_t;

  // All results raised by one input byte, in delivery order
  typedef struct packed {
    logic [1:0]                count;
    cst_result_t [MAX_RES-1:0] res;
  } cst_batch_t;

endpackage

`default_nettype wire

// ===== rtl/core/class_spec_tokenizer.sv =====
// Path: an accepted byte passes through the input register, then the result register,
// from which its first result transfers. Throughput: one byte per cycle while each
// byte raises at most one result and the output is not stalled; a byte that raises
// several results holds input until they drain from the result register.
// Reset: rst is synchronous, active high; it clears the scanner state and drops all
// pending results. There is no clearing pass.
`default_nettype none

module class_spec_tokenizer #(
  parameter int MAX_BUFFER = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic        s_tlast,   // end_of_buffer
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [7:0] symbol, [19:8] data_offset,
                                      // [31:20] data_length, [32] bad_quote, [39:33] zero
  output logic [1:0]       m_tuser,   // [1:0] event_kind
  output logic             m_tlast    // last
);
  import cst_pkg::*;

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_eob;
  logic        advance;
  logic        can_load;
  cst_batch_t  batch;
  cst_result_t head;

  assign advance  = in_valid && can_load;
  assign s_tready = !in_valid || advance;

  // Register the incoming byte
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_eob  <= s_tlast;
    end
  end

  cst_scan #(
    .MAX_BUFFER (MAX_BUFFER)
  ) u_scan (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .data_byte     (in_byte),
    .end_of_buffer (in_eob),
    .batch         (batch)
  );

  cst_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .batch    (batch),
    .pop      (m_tready),
    .can_load (can_load),
    .valid    (m_tvalid),
    .head     (head)
  );

  // Pack the result head onto the stream
  assign m_tdata = {7'd0, head.bad_quote, head.length, head.offset, head.symbol};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

endmodule

`default_nettype wire

// ===== rtl/core/cst_scan.sv =====
`default_nettype none

module cst_scan #(
  parameter int MAX_BUFFER = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire logic [7:0]        data_byte,
  input  wire logic              end_of_buffer,
  output cst_pkg::cst_batch_t    batch
);
  import cst_pkg::*;

  localparam logic [POS_W-1:0] SAT_LIMIT =
    POS_W'((MAX_BUFFER - 1 < 4095) ? MAX_BUFFER - 1 : 4095);

  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LBR   = 8'h7B;
  localparam logic [7:0] CH_RBR   = 8'h7D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
    return (v >= SAT_LIMIT) ? SAT_LIMIT : v + 1'b1;
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= CH_A) && (c <= CH_Z);
  endfunction

  function automatic logic plain_ok(input logic [7:0] c);
    return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_0) && (c <= CH_9)) ||
           (c == CH_DOT) || (c == CH_UNDER);
  endfunction

  function automatic logic quoted_ok(input logic [7:0] c);
    return ((c >= CH_LA) && (c <= CH_LZ)) || is_upper(c) ||
           ((c >= CH_0) && (c <= CH_9)) || (c == CH_UNDER) || (c == CH_DOT) ||
           (c == CH_SLASH) || (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_PCT);
  endfunction

  function automatic cst_result_t make_res(input cst_kind_t k, input logic [7:0] s,
                                           input logic [POS_W-1:0] o,
                                           input logic [POS_W-1:0] l,
                                           input logic b);
    cst_result_t r;
    r.kind      = k;
    r.symbol    = s;
    r.offset    = o;
    r.length    = l;
    r.bad_quote = b;
    r.last      = 1'b0;
    return r;
  endfunction

  // Tokenizer state
  cst_mode_t        scan_mode;
  logic [7:0]       class_letter;
  logic [POS_W-1:0] token_start;
  logic [POS_W-1:0] token_length;
  logic [POS_W-1:0] byte_position;
  logic             sticky_error;

  cst_mode_t        scan_mode_next;
  logic [7:0]       class_letter_next;
  logic [POS_W-1:0] token_start_next;
  logic [POS_W-1:0] token_length_next;
  logic [POS_W-1:0] byte_position_next;
  logic             sticky_error_next;

  // Walk one byte through the scanner and collect its results
  always_comb begin
    logic        rescan;
    logic        emit_tok;
    logic        tok_bad;
    logic [1:0]  n;
    cst_result_t r [MAX_RES];

    scan_mode_next     = scan_mode;
    class_letter_next  = class_letter;
    token_start_next   = token_start;
    token_length_next  = token_length;
    sticky_error_next  = sticky_error;
    byte_position_next = sat_inc(byte_position);
    rescan   = 1'b0;
    emit_tok = 1'b0;
    tok_bad  = 1'b0;
    n        = 2'd0;
    for (int i = 0; i < MAX_RES; i++) begin
      r[i] = make_res(KIND_TOKEN, 8'd0, '0, '0, 1'b0);
    end

    if (!sticky_error) begin
      unique case (scan_mode)
        MODE_LETTER: begin
          if (data_byte == CH_QUOTE) begin
            token_length_next = POS_W'(1);
            scan_mode_next    = MODE_QUOTED;
          end else if (plain_ok(data_byte)) begin
            token_length_next = POS_W'(1);
            scan_mode_next    = MODE_PLAIN;
          end else begin
            emit_tok = 1'b1;
            rescan   = 1'b1;
          end
        end
        MODE_PLAIN: begin
          if (plain_ok(data_byte)) begin
            token_length_next = sat_inc(token_length);
          end else begin
            emit_tok = 1'b1;
            rescan   = 1'b1;
          end
        end
        MODE_QUOTED: begin
          if (quoted_ok(data_byte)) begin
            token_length_next = sat_inc(token_length);
          end else if (data_byte == CH_QUOTE) begin
            token_length_next = sat_inc(token_length);
            emit_tok          = 1'b1;
          end else begin
            emit_tok = 1'b1;
            tok_bad  = 1'b1;
            rescan   = 1'b1;
          end
        end
        MODE_IDLE: begin
          rescan = 1'b1;
        end
        default: begin
          rescan = 1'b1;
        end
      endcase
    end

    // Close the open token
    if (emit_tok) begin
      r[n] = make_res(KIND_TOKEN, class_letter, token_start, token_length_next, tok_bad);
      n    = n + 2'd1;
      scan_mode_next = MODE_IDLE;
    end

    // Treat the byte as a fresh byte between tokens
    if (rescan) begin
      scan_mode_next = MODE_IDLE;
      if (is_upper(data_byte)) begin
        class_letter_next = data_byte;
        token_start_next  = sat_inc(byte_position);
        token_length_next = '0;
        scan_mode_next    = MODE_LETTER;
      end else if ((data_byte == CH_COMMA) || (data_byte == CH_LBR) ||
                   (data_byte == CH_RBR)) begin
        r[n] = make_res(KIND_DELIM, data_byte, '0, '0, 1'b0);
        n    = n + 2'd1;
      end else if ((data_byte != CH_SP) && (data_byte != CH_TAB) &&
                   (data_byte != CH_CR) && (data_byte != CH_LF)) begin
        r[n] = make_res(KIND_ERROR, data_byte, '0, '0, 1'b0);
        n    = n + 2'd1;
        sticky_error_next = 1'b1;
      end
    end

    // Flush at end of buffer and return to the reset state
    if (end_of_buffer) begin
      if ((scan_mode_next != MODE_IDLE) && !sticky_error_next) begin
        r[n] = make_res(KIND_TOKEN, class_letter_next, token_start_next,
                        token_length_next, 1'b0);
        n    = n + 2'd1;
      end
      r[n] = make_res(KIND_END, 8'd0, '0, '0, 1'b0);
      n    = n + 2'd1;
      scan_mode_next     = MODE_IDLE;
      class_letter_next  = 8'd0;
      token_start_next   = '0;
      token_length_next  = '0;
      byte_position_next = '0;
      sticky_error_next  = 1'b0;
    end

    // Mark the final result of this byte
    for (int i = 0; i < MAX_RES; i++) begin
      r[i].last = (2'(i) == n - 2'd1);
      batch.res[i] = r[i];
    end
    batch.count = n;
  end

  // Hold state between bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode     <= MODE_IDLE;
      class_letter  <= 8'd0;
      token_start   <= '0;
      token_length  <= '0;
      byte_position <= '0;
      sticky_error  <= 1'b0;
    end else if (advance) begin
      scan_mode     <= scan_mode_next;
      class_letter  <= class_letter_next;
      token_start   <= token_start_next;
      token_length  <= token_length_next;
      byte_position <= byte_position_next;
      sticky_error  <= sticky_error_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cst_outq.sv =====
`default_nettype none

module cst_outq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire cst_pkg::cst_batch_t batch,
  input  wire logic              pop,
  output logic                   can_load,
  output logic                   valid,
  output cst_pkg::cst_result_t   head
);
  import cst_pkg::*;

  cst_result_t [MAX_RES-1:0] entry;
  logic [1:0]                cnt;

  assign valid    = (cnt != 2'd0);
  assign head     = entry[0];
  // A new batch may land when the queue is empty or drains this cycle
  assign can_load = (cnt == 2'd0) || ((cnt == 2'd1) && pop);

  // Track the number of pending results
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= batch.count;
    end else if (valid && pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  // Load a batch or shift toward the head on each transfer
  always_ff @(posedge clk) begin
    if (load) begin
      entry <= batch.res;
    end else if (valid && pop) begin
      entry[0] <= entry[1];
      entry[1] <= entry[2];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cst_check.sv =====
`default_nettype none

module cst_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [7:0]  s_tdata,
  input wire logic        s_tlast,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic [1:0]  m_tuser,
  input wire logic        m_tlast
);
  import cst_pkg::*;

  // Nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result pending after reset");

  // End of buffer is always the closing result of its byte
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_END)) |-> (m_tlast && (m_tdata[7:0] == 8'd0)))
    else $error("end event not last or has a symbol");

  // Only tokens carry offset, length and the quote flag
  a_nontoken_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser != KIND_TOKEN)) |-> (m_tdata[39:8] == 32'd0))
    else $error("non-token event carries token fields");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                                 $stable(m_tlast)))
    else $error("stalled result changed");

  // A stalled input byte holds until it is taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && !s_tready) |=> (s_tvalid && $stable(s_tdata) && $stable(s_tlast)))
    else $error("stalled input byte changed");

endmodule

bind class_spec_tokenizer cst_check u_cst_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire
